// ===== rtl/go_back_n_sender_macros.svh =====
// Assertion macros shared by the go-back-N sender RTL.
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBN_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBN_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbn_pkg.sv =====
// Types, codes and microcode ROM of the go-back-N sender.
package gbn_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] F_BEGIN = 2'd0;
  localparam logic [1:0] F_ACK   = 2'd1;
  localparam logic [1:0] F_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_END   = 2'd1;
  localparam logic [1:0] K_DATA  = 2'd2;
  localparam logic [1:0] K_DONE  = 2'd3;

  // Transfer phase
  typedef logic [1:0] phase_t;
  localparam phase_t PH_IDLE  = 2'd0;
  localparam phase_t PH_START = 2'd1;
  localparam phase_t PH_DATA  = 2'd2;
  localparam phase_t PH_END   = 2'd3;

  // Register map (word index on the APB port)
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_WINDOW_SIZE   = 3'd0;
  localparam logic [2:0] REG_TOTAL_CHUNKS  = 3'd1;
  localparam logic [2:0] REG_RETRANS_TICKS = 3'd2;
  localparam logic [2:0] REG_START_TOKEN   = 3'd3;
  localparam logic [2:0] REG_END_TOKEN     = 3'd4;

  typedef struct packed {
    logic [4:0]  window_size;
    logic [31:0] total_chunks;
    logic [15:0] retrans_ticks;
    logic [31:0] start_token;
    logic [31:0] end_token;
  } gbn_cfg_t;

  // Microprogram addresses
  typedef logic [3:0] pc_t;
  localparam pc_t S_IDLE      = 4'd0;
  localparam pc_t S_BEGIN     = 4'd1;
  localparam pc_t S_ACK_START = 4'd2;
  localparam pc_t S_ACK_DATA  = 4'd3;
  localparam pc_t S_ACK_END   = 4'd4;
  localparam pc_t S_TICK      = 4'd5;
  localparam pc_t S_TICK_HS   = 4'd6;
  localparam pc_t S_HS_CHK    = 4'd7;
  localparam pc_t S_TICK_DATA = 4'd8;
  localparam pc_t S_DATA_CHK  = 4'd9;
  localparam pc_t S_RESEND    = 4'd10;
  localparam pc_t S_FILL      = 4'd11;
  localparam pc_t S_FILL_CHK  = 4'd12;

  // Jump conditions: when true the step jumps and does nothing else
  typedef logic [3:0] cond_sel_t;
  localparam cond_sel_t C_NEVER       = 4'd0;
  localparam cond_sel_t C_NO_IN       = 4'd1;
  localparam cond_sel_t C_BAD_START   = 4'd2;
  localparam cond_sel_t C_BAD_RANGE   = 4'd3;
  localparam cond_sel_t C_BAD_END     = 4'd4;
  localparam cond_sel_t C_NO_HS_TMO   = 4'd5;
  localparam cond_sel_t C_EMPTY       = 4'd6;
  localparam cond_sel_t C_NO_DATA_TMO = 4'd7;
  localparam cond_sel_t C_SCAN_DONE   = 4'd8;
  localparam cond_sel_t C_FULL        = 4'd9;
  localparam cond_sel_t C_NOT_EMPTY   = 4'd10;

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LATCH    = 4'd1;
  localparam op_t OP_BEGIN    = 4'd2;
  localparam op_t OP_PH_DATA  = 4'd3;
  localparam op_t OP_SLIDE    = 4'd4;
  localparam op_t OP_PH_IDLE  = 4'd5;
  localparam op_t OP_TICK     = 4'd6;
  localparam op_t OP_HS_MARK  = 4'd7;
  localparam op_t OP_REWIND   = 4'd8;
  localparam op_t OP_RESEND   = 4'd9;
  localparam op_t OP_FILL     = 4'd10;
  localparam op_t OP_PH_END   = 4'd11;

  // Result to load into the output register
  typedef logic [2:0] emit_t;
  localparam emit_t E_NONE   = 3'd0;
  localparam emit_t E_START  = 3'd1;
  localparam emit_t E_END    = 3'd2;
  localparam emit_t E_DONE   = 3'd3;
  localparam emit_t E_HS     = 3'd4;
  localparam emit_t E_DATA_S = 3'd5;
  localparam emit_t E_DATA_N = 3'd6;

  typedef struct packed {
    cond_sel_t cond;
    pc_t       jmp;
    op_t       op;
    emit_t     emit;
    logic      disp;
    pc_t       nxt;
  } ucode_t;

  // Sequencer to datapath: gated operation and result select
  typedef struct packed {
    op_t   op;
    emit_t emit;
  } gbn_ctrl_t;

  // Datapath to sequencer: status flags
  typedef struct packed {
    phase_t phase;
    logic   bad_start;
    logic   bad_range;
    logic   bad_end;
    logic   no_hs_tmo;
    logic   empty;
    logic   no_data_tmo;
    logic   scan_done;
    logic   full;
    logic   out_free;
  } gbn_cond_t;

  function automatic ucode_t uw(input cond_sel_t c, input pc_t j, input op_t o,
                                input emit_t e, input logic d, input pc_t n);
    ucode_t w;
    w.cond = c;
    w.jmp  = j;
    w.op   = o;
    w.emit = e;
    w.disp = d;
    w.nxt  = n;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      S_IDLE:      w = uw(C_NO_IN,       S_IDLE,     OP_LATCH,   E_NONE,   1'b1, S_IDLE);
      S_BEGIN:     w = uw(C_NEVER,       S_IDLE,     OP_BEGIN,   E_START,  1'b0, S_IDLE);
      S_ACK_START: w = uw(C_BAD_START,   S_IDLE,     OP_PH_DATA, E_NONE,   1'b0, S_FILL);
      S_ACK_DATA:  w = uw(C_BAD_RANGE,   S_IDLE,     OP_SLIDE,   E_NONE,   1'b0, S_FILL);
      S_ACK_END:   w = uw(C_BAD_END,     S_IDLE,     OP_PH_IDLE, E_DONE,   1'b0, S_IDLE);
      S_TICK:      w = uw(C_NEVER,       S_IDLE,     OP_TICK,    E_NONE,   1'b0, S_IDLE);
      S_TICK_HS:   w = uw(C_NEVER,       S_IDLE,     OP_TICK,    E_NONE,   1'b0, S_HS_CHK);
      S_HS_CHK:    w = uw(C_NO_HS_TMO,   S_IDLE,     OP_HS_MARK, E_HS,     1'b0, S_IDLE);
      S_TICK_DATA: w = uw(C_EMPTY,       S_TICK,     OP_TICK,    E_NONE,   1'b0, S_DATA_CHK);
      S_DATA_CHK:  w = uw(C_NO_DATA_TMO, S_IDLE,     OP_REWIND,  E_NONE,   1'b0, S_RESEND);
      S_RESEND:    w = uw(C_SCAN_DONE,   S_IDLE,     OP_RESEND,  E_DATA_S, 1'b0, S_RESEND);
      S_FILL:      w = uw(C_FULL,        S_FILL_CHK, OP_FILL,    E_DATA_N, 1'b0, S_FILL);
      S_FILL_CHK:  w = uw(C_NOT_EMPTY,   S_IDLE,     OP_PH_END,  E_END,    1'b0, S_IDLE);
      default:     w = uw(C_NEVER,       S_IDLE,     OP_NONE,    E_NONE,   1'b0, S_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of the routine for an accepted event
  function automatic pc_t gbn_dispatch(input logic [1:0] func, input phase_t phase);
    pc_t p;
    p = S_IDLE;
    case (func)
      F_BEGIN: begin
        if (phase == PH_IDLE) p = S_BEGIN;
      end
      F_ACK: begin
        case (phase)
          PH_START: p = S_ACK_START;
          PH_DATA:  p = S_ACK_DATA;
          PH_END:   p = S_ACK_END;
          default:  p = S_IDLE;
        endcase
      end
      F_TICK: begin
        case (phase)
          PH_IDLE: p = S_TICK;
          PH_DATA: p = S_TICK_DATA;
          default: p = S_TICK_HS;
        endcase
      end
      default: p = S_IDLE;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/go_back_n_sender.sv =====
// Go-back-N ARQ sender top level: register file, sequencer and datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid / in_stall     | in_func, in_ack_seq
//  out     | output    | out_valid / out_stall   | out_pkt_kind, out_pkt_seq, out_last
//  cfg     | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// One event is processed at a time by a microcoded sequencer; in_stall is high
// from the cycle after a transfer until its routine returns to the idle step.
// Every issued packet takes one step, so the send loop sets the rate.
// A step that loads a result waits while the output register holds a stalled
// transfer; the next event is taken while the final result still waits.
// Reset is synchronous, active low: phase idle, window and clock at zero,
// registers at their documented defaults. Send times are written before use.

module go_back_n_sender import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [31:0]       in_ack_seq,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_pkt_kind,
  output logic [31:0]       out_pkt_seq,
  output logic              out_last,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  gbn_cfg_t   cfg_r, cfg_nxt;
  gbn_ctrl_t  ctrl;
  gbn_cond_t  cond;
  logic [2:0] reg_idx;
  logic       busy;

  // Word-aligned registers: index is the address divided by four
  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW_SIZE:   cfg_nxt.window_size   = pwdata[4:0];
        REG_TOTAL_CHUNKS:  cfg_nxt.total_chunks  = pwdata;
        REG_RETRANS_TICKS: cfg_nxt.retrans_ticks = pwdata[15:0];
        REG_START_TOKEN:   cfg_nxt.start_token   = pwdata;
        REG_END_TOKEN:     cfg_nxt.end_token     = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_SIZE:   prdata = 32'(cfg_r.window_size);
      REG_TOTAL_CHUNKS:  prdata = cfg_r.total_chunks;
      REG_RETRANS_TICKS: prdata = 32'(cfg_r.retrans_ticks);
      REG_START_TOKEN:   prdata = cfg_r.start_token;
      REG_END_TOKEN:     prdata = cfg_r.end_token;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size   <= 5'd16;
      cfg_r.total_chunks  <= '0;
      cfg_r.retrans_ticks <= 16'd500;
      cfg_r.start_token   <= '0;
      cfg_r.end_token     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Events are taken only at the idle step of the microprogram
  assign in_stall = busy;

  gbn_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .cond     (cond),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  gbn_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cfg          (cfg_r),
    .in_ack_seq   (in_ack_seq),
    .out_stall    (out_stall),
    .cond         (cond),
    .out_valid    (out_valid),
    .out_pkt_kind (out_pkt_kind),
    .out_pkt_seq  (out_pkt_seq),
    .out_last     (out_last)
  );

endmodule

// ===== rtl/gbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gbn_seq.sv =====
// Microcode sequencer: step counter, control ROM, condition select, dispatch.
`include "go_back_n_sender_macros.svh"

module gbn_seq import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  gbn_cond_t  cond,
  output gbn_ctrl_t  ctrl,
  output logic       busy
);

  pc_t    pc_r, pc_nxt;
  ucode_t word;
  logic   cond_hit;
  logic   blocked;

  assign word = ucode_rom(pc_r);

  always_comb begin
    case (word.cond)
      C_NEVER:       cond_hit = 1'b0;
      C_NO_IN:       cond_hit = !in_valid;
      C_BAD_START:   cond_hit = cond.bad_start;
      C_BAD_RANGE:   cond_hit = cond.bad_range;
      C_BAD_END:     cond_hit = cond.bad_end;
      C_NO_HS_TMO:   cond_hit = cond.no_hs_tmo;
      C_EMPTY:       cond_hit = cond.empty;
      C_NO_DATA_TMO: cond_hit = cond.no_data_tmo;
      C_SCAN_DONE:   cond_hit = cond.scan_done;
      C_FULL:        cond_hit = cond.full;
      C_NOT_EMPTY:   cond_hit = !cond.empty;
      default:       cond_hit = 1'b0;
    endcase
  end

  // a step that loads a result waits for a free output register
  assign blocked = !cond_hit && (word.emit != E_NONE) && !cond.out_free;

  always_comb begin
    pc_nxt    = pc_r;
    ctrl.op   = OP_NONE;
    ctrl.emit = E_NONE;
    if (cond_hit) begin
      pc_nxt = word.jmp;
    end else if (!blocked) begin
      ctrl.op   = word.op;
      ctrl.emit = word.emit;
      pc_nxt    = word.disp ? gbn_dispatch(in_func, cond.phase) : word.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= S_IDLE;
    else        pc_r <= pc_nxt;
  end

  assign busy = (pc_r != S_IDLE);

  `GBN_ASSERT_NXT(a_seq_hold_on_stall, clk, rst_n, blocked, $stable(pc_r), "step advanced while output blocked")

endmodule

// ===== rtl/gbn_dp.sv =====
// Sender datapath: window state, send-time RAM, timers and output register.
`include "go_back_n_sender_macros.svh"

module gbn_dp import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gbn_ctrl_t   ctrl,
  input  gbn_cfg_t    cfg,
  input  logic [31:0] in_ack_seq,
  input  logic        out_stall,
  output gbn_cond_t   cond,
  output logic        out_valid,
  output logic [1:0]  out_pkt_kind,
  output logic [31:0] out_pkt_seq,
  output logic        out_last
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = $clog2(2 * WINDOW_MAX);
  localparam int EW = $clog2(WINDOW_MAX + 1);

  phase_t        phase_r, phase_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   next_r, next_nxt;
  logic [31:0]   scan_r, scan_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [31:0]   hs_r, hs_nxt;
  logic [31:0]   ack_r, ack_nxt;
  logic [IW-1:0] bidx_r, bidx_nxt;
  logic [IW-1:0] nidx_r, nidx_nxt;
  logic [IW-1:0] sidx_r, sidx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [31:0]   out_seq_r, out_seq_nxt;
  logic          out_last_r, out_last_nxt;

  logic [EW-1:0] w_eff;
  logic [31:0]   inflight;
  logic [31:0]   rt32;
  logic [31:0]   sent_at;
  logic          last_fill;
  logic [SW-1:0] slide_sum;
  logic [IW-1:0] slide_idx;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, i} + (IW+1)'(1);
    if (s == (IW+1)'(WINDOW_MAX)) return '0;
    return s[IW-1:0];
  endfunction

  // window register clamped to 1..WINDOW_MAX
  always_comb begin
    if (cfg.window_size == 5'd0)
      w_eff = EW'(1);
    else if (32'(cfg.window_size) > 32'(WINDOW_MAX))
      w_eff = EW'(WINDOW_MAX);
    else
      w_eff = EW'(cfg.window_size);
  end

  assign inflight  = next_r - base_r;
  assign rt32      = 32'(cfg.retrans_ticks);
  assign last_fill = (inflight + 32'd1 == 32'(w_eff)) || (next_r + 32'd1 == cfg.total_chunks);

  // slide never exceeds the packets in flight, so one subtract wraps the index
  always_comb begin
    slide_sum = SW'(bidx_r) + SW'(ack_r - base_r);
    if (slide_sum >= SW'(WINDOW_MAX)) slide_sum = slide_sum - SW'(WINDOW_MAX);
    slide_idx = IW'(slide_sum);
  end

  assign ram_we    = (ctrl.op == OP_RESEND) || (ctrl.op == OP_FILL);
  assign ram_waddr = (ctrl.op == OP_RESEND) ? sidx_r : nidx_r;

  gbn_ram #(.WIDTH(32), .DEPTH(WINDOW_MAX)) u_send_time (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (now_r),
    .raddr (bidx_r),
    .rdata (sent_at)
  );

  always_comb begin
    cond.phase       = phase_r;
    cond.bad_start   = (ack_r != cfg.start_token);
    cond.bad_end     = (ack_r != cfg.end_token);
    cond.bad_range   = !((ack_r > base_r) && (ack_r <= next_r));
    cond.no_hs_tmo   = ((now_r - hs_r) < rt32);
    cond.empty       = (next_r == base_r);
    cond.no_data_tmo = ((now_r - sent_at) < rt32);
    cond.scan_done   = (scan_r == next_r);
    cond.full        = !((inflight < 32'(w_eff)) && (next_r < cfg.total_chunks));
    cond.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    next_nxt  = next_r;
    scan_nxt  = scan_r;
    now_nxt   = now_r;
    hs_nxt    = hs_r;
    ack_nxt   = ack_r;
    bidx_nxt  = bidx_r;
    nidx_nxt  = nidx_r;
    sidx_nxt  = sidx_r;
    case (ctrl.op)
      OP_LATCH: ack_nxt = in_ack_seq;
      OP_BEGIN: begin
        base_nxt  = '0;
        next_nxt  = '0;
        bidx_nxt  = '0;
        nidx_nxt  = '0;
        phase_nxt = PH_START;
        hs_nxt    = now_r;
      end
      OP_PH_DATA: phase_nxt = PH_DATA;
      OP_SLIDE: begin
        base_nxt = ack_r;
        bidx_nxt = slide_idx;
      end
      OP_PH_IDLE: phase_nxt = PH_IDLE;
      OP_TICK:    now_nxt = now_r + 32'd1;
      OP_HS_MARK: hs_nxt = now_r;
      OP_REWIND: begin
        scan_nxt = base_r;
        sidx_nxt = bidx_r;
      end
      OP_RESEND: begin
        scan_nxt = scan_r + 32'd1;
        sidx_nxt = idx_inc(sidx_r);
      end
      OP_FILL: begin
        next_nxt = next_r + 32'd1;
        nidx_nxt = idx_inc(nidx_r);
      end
      OP_PH_END: begin
        phase_nxt = PH_END;
        hs_nxt    = now_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    case (ctrl.emit)
      E_START: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_START;
        out_seq_nxt   = cfg.start_token;
        out_last_nxt  = 1'b1;
      end
      E_END: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_END;
        out_seq_nxt   = cfg.end_token;
        out_last_nxt  = 1'b1;
      end
      E_DONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_DONE;
        out_seq_nxt   = '0;
        out_last_nxt  = 1'b1;
      end
      E_HS: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = (phase_r == PH_START) ? K_START : K_END;
        out_seq_nxt   = (phase_r == PH_START) ? cfg.start_token : cfg.end_token;
        out_last_nxt  = 1'b1;
      end
      E_DATA_S: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_DATA;
        out_seq_nxt   = scan_r;
        out_last_nxt  = (scan_r + 32'd1 == next_r);
      end
      E_DATA_N: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_DATA;
        out_seq_nxt   = next_r;
        out_last_nxt  = last_fill;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      now_r       <= '0;
      hs_r        <= '0;
      bidx_r      <= '0;
      nidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      now_r       <= now_nxt;
      hs_r        <= hs_nxt;
      bidx_r      <= bidx_nxt;
      nidx_r      <= nidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    ack_r      <= ack_nxt;
    sidx_r     <= sidx_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pkt_kind = out_kind_r;
  assign out_pkt_seq  = out_seq_r;
  assign out_last     = out_last_r;

  `GBN_ASSERT_IMP(a_dp_inflight_bound, clk, rst_n, phase_r == PH_DATA, inflight <= 32'(WINDOW_MAX), "more packets in flight than the window holds")
  `GBN_ASSERT_IMP(a_dp_window_empty, clk, rst_n, phase_r != PH_DATA, next_r == base_r, "window not empty outside the data phase")
  `GBN_ASSERT_IMP(a_dp_emit_free, clk, rst_n, ctrl.emit != E_NONE, !out_valid_r || !out_stall, "result loaded over a stalled one")

endmodule

// ===== sim/go_back_n_sender_tb.sv =====
// Self-checking testbench of the go-back-N sender: predictor, scoreboard and stimulus.
module go_back_n_sender_tb import gbn_pkg::*; ();

  localparam int WIN_MAX    = 16;
  // Quiet cycles after the last result, enough to cover the longest routine.
  localparam int SETTLE     = 40;
  localparam int RAND_ITEMS = 170;
  localparam int TAIL_ITEMS = 30;
  localparam int LIMIT      = 400000;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AT    = 45;
  // Event code outside the defined set; the block must drop it.
  localparam logic [1:0] F_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic        last;
  } pkt_t;

  // Sender predictor: tracks the ARQ state and queues the packets each event causes.
  class send_predictor;
    logic [4:0]  win;
    logic [31:0] total;
    logic [15:0] rto;
    logic [31:0] tok_start;
    logic [31:0] tok_end;
    phase_t      phase;
    logic [31:0] base;
    logic [31:0] nxt;
    logic [31:0] now;
    logic [31:0] hs_at;
    logic [31:0] sent_at [WIN_MAX];
    pkt_t        pending_pkts [$];
    pkt_t        item_pkts [$];
    int          errors;

    function new();
      win = 5'd16;
      total = '0;
      rto = 16'd500;
      tok_start = '0;
      tok_end = '0;
      phase = PH_IDLE;
      base = '0;
      nxt = '0;
      now = '0;
      hs_at = '0;
      foreach (sent_at[i]) sent_at[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_WINDOW_SIZE:   win = val[4:0];
        REG_TOTAL_CHUNKS:  total = val;
        REG_RETRANS_TICKS: rto = val[15:0];
        REG_START_TOKEN:   tok_start = val;
        REG_END_TOKEN:     tok_end = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pkts.size();
    endfunction

    function void emit(logic [1:0] k, logic [31:0] q);
      pkt_t p;
      p.kind = k;
      p.seq = q;
      p.last = 1'b0;
      if (item_pkts.size() < 32) item_pkts = {item_pkts, p};
    endfunction

    function int unsigned eff_win();
      if (win == 5'd0) return 1;
      if (win > WIN_MAX) return WIN_MAX;
      return win;
    endfunction

    function void send_data(logic [31:0] s);
      sent_at[s % WIN_MAX] = now;
      emit(K_DATA, s);
    endfunction

    // Top up the window; an empty window means the data phase is over.
    function void fill();
      int unsigned w;
      w = eff_win();
      while ((nxt - base) < w && nxt < total) begin
        send_data(nxt);
        nxt = nxt + 1;
      end
      if (nxt == base) begin
        phase = PH_END;
        hs_at = now;
        emit(K_END, tok_end);
      end
    endfunction

    // Apply one accepted event and queue the packets it causes.
    function void note_event(logic [1:0] f, logic [31:0] a);
      logic [31:0] s;
      item_pkts.delete();
      case (f)
        F_BEGIN: begin
          if (phase == PH_IDLE) begin
            base = '0;
            nxt = '0;
            phase = PH_START;
            hs_at = now;
            emit(K_START, tok_start);
          end
        end
        F_ACK: begin
          case (phase)
            PH_START: begin
              if (a == tok_start) begin
                phase = PH_DATA;
                fill();
              end
            end
            PH_DATA: begin
              if (a > base && a <= nxt) begin
                base = a;
                fill();
              end
            end
            PH_END: begin
              if (a == tok_end) begin
                phase = PH_IDLE;
                emit(K_DONE, 32'd0);
              end
            end
            default: ;
          endcase
        end
        F_TICK: begin
          now = now + 1;
          if (phase == PH_START || phase == PH_END) begin
            if ((now - hs_at) >= {16'd0, rto}) begin
              hs_at = now;
              if (phase == PH_START) emit(K_START, tok_start);
              else emit(K_END, tok_end);
            end
          end else if (phase == PH_DATA && nxt != base) begin
            if ((now - sent_at[base % WIN_MAX]) >= {16'd0, rto}) begin
              for (s = base; s != nxt; s = s + 1) send_data(s);
            end
          end
        end
        default: ;
      endcase
      if (item_pkts.size() > 0) item_pkts[item_pkts.size() - 1].last = 1'b1;
      pending_pkts = {pending_pkts, item_pkts};
    endfunction

    function void check_pkt(pkt_t got);
      pkt_t exp_p;
      if (pending_pkts.size() == 0) begin
        errors++;
        $display("%0t: packet with none pending: kind %0d seq %h last %0b",
                 $time, got.kind, got.seq, got.last);
        return;
      end
      exp_p = pending_pkts[0];
      pending_pkts.delete(0);
      if (got.kind !== exp_p.kind) begin
        errors++;
        $display("%0t: pkt_kind expected %0d got %0d", $time, exp_p.kind, got.kind);
      end
      if (got.seq !== exp_p.seq) begin
        errors++;
        $display("%0t: pkt_seq expected %h got %h", $time, exp_p.seq, got.seq);
      end
      if (got.last !== exp_p.last) begin
        errors++;
        $display("%0t: last expected %0b got %0b", $time, exp_p.last, got.last);
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = F_TICK;
  logic [31:0]       in_ack_seq = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_pkt_kind;
  logic [31:0]       out_pkt_seq;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  send_predictor pred;
  int unsigned   cycles = 0;
  int unsigned   pkts_seen = 0;
  int            items_sent = 0;
  bit            tx_fast = 1'b0;
  bit            long_hold_done = 1'b0;

  go_back_n_sender #(.WINDOW_MAX(WIN_MAX)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_ack_seq(in_ack_seq),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pkt_kind(out_pkt_kind),
    .out_pkt_seq(out_pkt_seq),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Single reset pulse at the start of the run.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("go_back_n_sender verification failed");
      $finish;
    end
  end

  // Result side. Each transfer is preceded by a random stall, which may be none; every third
  // block of 64 packets runs with no stall, and once the receiver holds off for LONG_HOLD
  // so the output register backs up and the block stalls its input.
  // Signals are read right after the edge, so they hold the values the block saw there.
  initial begin : receiver
    int   gap;
    pkt_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && pkts_seen >= HOLD_AT) begin
        gap = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if ((pkts_seen / 64) % 3 == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.kind = out_pkt_kind;
      got.seq  = out_pkt_seq;
      got.last = out_last;
      pred.check_pkt(got);
      pkts_seen++;
    end
  end

  // Offer one event after a random gap and hold it until the transfer completes.
  // Valid stays high across back-to-back events; it only drops when a gap is drawn.
  task automatic send_item(input logic [1:0] f, input logic [31:0] a);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_ack_seq <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.note_event(f, a);
    items_sent++;
  endtask

  // Wait until every predicted packet has come out, then let the sequencer settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then idle before the next write.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pred.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change with the block drained of pending packets.
  task automatic write_config(input logic [4:0] w, input logic [31:0] t,
                              input logic [15:0] rt, input logic [31:0] ts,
                              input logic [31:0] te);
    drain();
    cfg_write(REG_WINDOW_SIZE, {27'd0, w});
    cfg_write(REG_TOTAL_CHUNKS, t);
    cfg_write(REG_RETRANS_TICKS, {16'd0, rt});
    cfg_write(REG_START_TOKEN, ts);
    cfg_write(REG_END_TOKEN, te);
  endtask

  task automatic random_config();
    logic [4:0]  w;
    logic [31:0] t;
    logic [15:0] rt;
    logic [31:0] ts;
    logic [31:0] te;
    int          r;
    r = $urandom_range(0, 9);
    w = (r == 0) ? 5'd0 : (r == 1) ? 5'd1 : (r == 2) ? 5'd16 : (r == 3) ? 5'd31 :
        5'($urandom_range(0, 31));
    r = $urandom_range(0, 9);
    t = (r == 0) ? 32'd0 : (r < 8) ? 32'($urandom_range(1, 20)) :
        32'($urandom_range(21, 48));
    r = $urandom_range(0, 9);
    rt = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd1 :
         16'($urandom_range(2, 12));
    r = $urandom_range(0, 9);
    ts = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    te = (r == 2) ? 32'd0 : (r == 3) ? 32'hFFFF_FFFF : $urandom;
    write_config(w, t, rt, ts, te);
  endtask

  // Mostly well-formed protocol traffic picked from the predicted phase, with stray
  // ACKs, early ticks, repeated begins and undefined codes mixed in.
  task automatic play_transfers(input int xfers, input int max_items);
    logic [1:0]  f;
    logic [31:0] a;
    phase_t      ph;
    int          done;
    int          n;
    int          r;
    done = 0;
    n = 0;
    while (done < xfers && n < max_items) begin
      r = $urandom_range(0, 99);
      a = $urandom;
      case (pred.phase)
        PH_IDLE: f = (r < 85) ? F_BEGIN : 2'($urandom_range(1, 3));
        PH_START: begin
          if (r < 65) begin
            f = F_ACK;
            a = pred.tok_start;
          end else if (r < 85) begin
            f = F_TICK;
          end else begin
            f = 2'($urandom_range(0, 3));
          end
        end
        PH_DATA: begin
          if (r < 55) begin
            // cumulative ACK somewhere inside the open window
            f = F_ACK;
            a = pred.base + $urandom_range(1, pred.nxt - pred.base);
          end else if (r < 80) begin
            f = F_TICK;
          end else if (r < 88) begin
            // just past the window, or anywhere at all
            f = F_ACK;
            if (r < 84) a = pred.nxt + 1;
          end else if (r < 93) begin
            f = F_ACK;
            a = pred.base;
          end else begin
            f = (r < 96) ? F_BEGIN : F_NOP;
          end
        end
        default: begin
          if (r < 60) begin
            f = F_ACK;
            a = pred.tok_end;
          end else if (r < 85) begin
            f = F_TICK;
          end else begin
            f = 2'($urandom_range(0, 3));
          end
        end
      endcase
      ph = pred.phase;
      send_item(f, a);
      n++;
      if (ph == PH_END && pred.phase == PH_IDLE) done++;
    end
  endtask

  initial begin : stimulus
    pred = new();
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Reset settings: window 16, no chunks, timeout 500, both tokens zero.
    send_item(F_TICK, 32'h0000_0000);      // tick while idle
    send_item(F_ACK, 32'hFFFF_FFFF);       // ACK while idle
    send_item(F_NOP, 32'hFFFF_FFFF);       // undefined code
    send_item(F_BEGIN, 32'h0000_0000);     // START
    send_item(F_BEGIN, 32'h0000_0000);     // begin while running
    send_item(F_ACK, 32'h0000_0005);       // wrong start token
    send_item(F_ACK, 32'h0000_0000);       // empty transfer: straight to END
    send_item(F_TICK, 32'h0000_0000);      // no timeout yet
    send_item(F_ACK, 32'h1234_5678);       // wrong end token
    send_item(F_ACK, 32'h0000_0000);       // complete

    // Window 0 acts as 1, zero timeout resends on every tick.
    write_config(5'd0, 32'd3, 16'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(F_BEGIN, 32'h0000_0000);
    send_item(F_TICK, 32'h0000_0000);      // START again
    send_item(F_ACK, 32'hFFFF_FFFF);       // DATA 0
    send_item(F_TICK, 32'h0000_0000);      // resend DATA 0
    send_item(F_ACK, 32'h0000_0005);       // beyond next_seq
    send_item(F_ACK, 32'h0000_0000);       // not above base
    send_item(F_ACK, 32'h0000_0001);
    send_item(F_ACK, 32'h0000_0002);
    send_item(F_ACK, 32'h0000_0003);       // window empty: END
    send_item(F_TICK, 32'h0000_0000);      // END again
    send_item(F_ACK, 32'h8000_0000);       // complete

    // Random part. Window 31 is clamped to 16; the long receiver hold lands in here.
    write_config(5'd31, 32'd40, 16'd3, 32'h0000_0000, 32'hFFFF_FFFF);
    play_transfers(2, 1000);
    tx_fast = 1'b1;
    write_config(5'd16, 32'd24, 16'hFFFF, $urandom, $urandom);
    play_transfers(1, 1000);
    while (items_sent < RAND_ITEMS - TAIL_ITEMS) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      random_config();
      play_transfers($urandom_range(1, 2), RAND_ITEMS - TAIL_ITEMS - items_sent);
    end

    // Largest chunk count: the transfer is left running at the end.
    tx_fast = 1'b0;
    write_config(5'd16, 32'hFFFF_FFFF, 16'd4, $urandom, $urandom);
    play_transfers(1, TAIL_ITEMS);

    in_valid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("go_back_n_sender verification clean");
    end else begin
      $display("go_back_n_sender verification failed");
    end
    $finish;
  end

endmodule
